// ===== rtl/evag_pkg.sv =====
// Shared types and constants for the energy voice activity gate.
// Holds field widths, register indexes, reset values and the
// command / status structs between controller and datapath.
package evag_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SQ_W      = 31;
    localparam int ENERGY_W  = 31;
    localparam int TOTAL_W   = 32;
    localparam int RATIO_W   = 16;
    localparam int FRAMES_W  = 16;
    localparam int CFG_W     = 31;
    localparam int IDX_W     = 2;
    localparam int PROD_W    = ENERGY_W + RATIO_W;
    localparam int OUT_W     = 2 + 2 * ENERGY_W + 2 * TOTAL_W;

    localparam int RISE_SHIFT  = 8;
    localparam int TRACK_SHIFT = 4;

    localparam logic [IDX_W-1:0] REG_SPEECH_RATIO    = 2'd0;
    localparam logic [IDX_W-1:0] REG_NOISE_FLOOR_MIN = 2'd1;
    localparam logic [IDX_W-1:0] REG_ATTACK_FRAMES   = 2'd2;
    localparam logic [IDX_W-1:0] REG_HANGOVER_FRAMES = 2'd3;

    localparam logic [RATIO_W-1:0]  RATIO_RST    = 16'd512;
    localparam logic [ENERGY_W-1:0] NF_MIN_RST   = 31'd40000;
    localparam logic [FRAMES_W-1:0] ATTACK_RST   = 16'd2;
    localparam logic [FRAMES_W-1:0] HANGOVER_RST = 16'd25;
    localparam logic [FRAMES_W-1:0] RUN_MAX      = 16'hFFFF;

    typedef struct packed {
        logic accept;
        logic load_div;
        logic div_step;
        logic mul;
        logic cmp;
        logic adapt;
        logic noise;
        logic out_load;
    } evag_cmd_t;

    typedef struct packed {
        logic frame_close;
        logic div_last;
        logic out_free;
    } evag_sts_t;

endpackage

// ===== rtl/evag_ctrl.sv =====
// Sequencer for the energy voice activity gate.
// Steps each closed frame through divide, threshold, gate, noise update and output.
// Depends on evag_pkg.
module evag_ctrl
    import evag_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  evag_sts_t sts,
    output logic      s_tready,
    output evag_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_ACC,
        ST_FOLD,
        ST_LOAD,
        ST_DIV,
        ST_MUL,
        ST_CMP,
        ST_ADAPT,
        ST_NOISE,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.accept = s_tvalid && s_tready_reg;
        unique case (state_reg)
            ST_ACC: begin
                if (cmd.accept && sts.frame_close) state_next = ST_FOLD;
            end
            ST_FOLD:  state_next = ST_LOAD;
            ST_LOAD: begin
                cmd.load_div = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.cmp    = 1'b1;
                state_next = ST_ADAPT;
            end
            ST_ADAPT: begin
                cmd.adapt  = 1'b1;
                state_next = ST_NOISE;
            end
            ST_NOISE: begin
                cmd.noise  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                cmd.out_load = sts.out_free;
                if (sts.out_free) state_next = ST_ACC;
            end
            default: state_next = ST_ACC;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_ACC;
            s_tready_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == ST_ACC);
        end
    end

    assign s_tready = s_tready_reg;

endmodule

// ===== rtl/evag_dpath.sv =====
// Datapath for the energy voice activity gate: settings, square accumulator,
// restoring divider, threshold multipliers, gate counters and output word.
// Depends on evag_pkg; driven by evag_ctrl.
module evag_dpath
    import evag_pkg::*;
#(
    parameter int MAX_FRAME   = 4096,
    parameter int RATIO_SCALE = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  evag_cmd_t            cmd,
    output evag_sts_t            sts,
    input  logic [SAMPLE_W-1:0]  s_tdata,
    input  logic                 s_tlast,
    input  logic                 cfg_we,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata
);

    localparam int CNT_W  = $clog2(MAX_FRAME + 1);
    localparam int SUM_W  = 30 + CNT_W;
    localparam int STEP_W = $clog2(SUM_W);
    localparam int RS_W   = $clog2(RATIO_SCALE + 1);
    localparam int ESC_W  = ENERGY_W + RS_W;
    localparam int CMP_W  = (ESC_W > PROD_W) ? ESC_W : PROD_W;
    localparam logic [RS_W-1:0]  RS       = RS_W'(RATIO_SCALE);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_FRAME - 1);

    // settings
    logic [RATIO_W-1:0]  ratio_reg;
    logic [ENERGY_W-1:0] nf_min_reg;
    logic [FRAMES_W-1:0] attack_reg;
    logic [FRAMES_W-1:0] hangover_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg    <= RATIO_RST;
            nf_min_reg   <= NF_MIN_RST;
            attack_reg   <= ATTACK_RST;
            hangover_reg <= HANGOVER_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SPEECH_RATIO:    ratio_reg    <= cfg_wdata[RATIO_W-1:0];
                REG_NOISE_FLOOR_MIN: nf_min_reg   <= cfg_wdata[ENERGY_W-1:0];
                REG_ATTACK_FRAMES:   attack_reg   <= cfg_wdata[FRAMES_W-1:0];
                REG_HANGOVER_FRAMES: hangover_reg <= cfg_wdata[FRAMES_W-1:0];
                default: ;
            endcase
        end
    end

    // square and accumulate
    logic signed [SAMPLE_W:0] sx;
    logic [SAMPLE_W:0]        mag;
    logic [2*SAMPLE_W+1:0]    sq_full;
    logic [SQ_W-1:0]          sq_reg;
    logic                     sq_vld_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_inc;

    assign sx      = {s_tdata[SAMPLE_W-1], s_tdata};
    assign mag     = s_tdata[SAMPLE_W-1] ? (SAMPLE_W+1)'(-sx) : (SAMPLE_W+1)'(sx);
    assign sq_full = mag * mag;
    assign cnt_inc = CNT_W'(cnt_reg + 1'b1);
    assign sts.frame_close = s_tlast || (cnt_reg == CNT_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg <= 1'b0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
        end else begin
            sq_vld_reg <= cmd.accept;
            if (cmd.accept) begin
                cnt_reg <= sts.frame_close ? '0 : cnt_inc;
            end
            if (cmd.load_div) begin
                sum_reg <= '0;
            end else if (sq_vld_reg) begin
                sum_reg <= sum_reg + SUM_W'(sq_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sq_reg <= sq_full[SQ_W-1:0];
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [CNT_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    dvs_ext;
    logic              ge;
    logic [ENERGY_W-1:0] energy;

    assign shifted      = {rem_reg, quo_reg[SUM_W-1]};
    assign dvs_ext      = {1'b0, dvs_reg};
    assign ge           = (shifted >= dvs_ext);
    assign sts.div_last = (step_reg == '0);
    assign energy       = quo_reg[ENERGY_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.accept && sts.frame_close) begin
            dvs_reg <= cnt_inc;
        end
        if (cmd.load_div) begin
            quo_reg  <= sum_reg;
            rem_reg  <= '0;
            step_reg <= STEP_W'(SUM_W - 1);
        end else if (cmd.div_step) begin
            rem_reg  <= ge ? CNT_W'(shifted - dvs_ext) : CNT_W'(shifted);
            quo_reg  <= {quo_reg[SUM_W-2:0], ge};
            step_reg <= STEP_W'(step_reg - 1'b1);
        end
    end

    // threshold: energy * scale against noise * ratio
    logic [ENERGY_W-1:0] noise_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ESC_W-1:0]    escal_reg;
    logic                speech_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg  <= noise_reg * ratio_reg;
            escal_reg <= energy * RS;
        end
        if (cmd.cmp) begin
            speech_reg <= (CMP_W'(escal_reg) > CMP_W'(prod_reg));
        end
    end

    // gate counters and noise tracking
    logic [ENERGY_W-1:0] delta_reg;
    logic                add_reg;
    logic                sub_reg;
    logic [FRAMES_W-1:0] run_reg;
    logic [FRAMES_W-1:0] hang_reg;
    logic                active_reg;
    logic [TOTAL_W-1:0]  spc_total_reg;
    logic [TOTAL_W-1:0]  frm_total_reg;

    logic                up;
    logic [ENERGY_W-1:0] diff;
    logic [FRAMES_W-1:0] run_inc;
    logic [FRAMES_W-1:0] hang_dec;
    logic [ENERGY_W-1:0] noise_adj;

    assign up        = (energy > noise_reg);
    assign diff      = up ? (energy - noise_reg) : (noise_reg - energy);
    assign run_inc   = (run_reg == RUN_MAX) ? run_reg : FRAMES_W'(run_reg + 1'b1);
    assign hang_dec  = (hang_reg != '0) ? FRAMES_W'(hang_reg - 1'b1) : hang_reg;
    assign noise_adj = add_reg ? (noise_reg + delta_reg) :
                       sub_reg ? (noise_reg - delta_reg) : noise_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_reg     <= NF_MIN_RST;
            run_reg       <= '0;
            hang_reg      <= '0;
            active_reg    <= 1'b0;
            spc_total_reg <= '0;
            frm_total_reg <= '0;
        end else begin
            if (cmd.adapt) begin
                frm_total_reg <= TOTAL_W'(frm_total_reg + 1'b1);
                if (speech_reg) begin
                    spc_total_reg <= TOTAL_W'(spc_total_reg + 1'b1);
                    run_reg       <= run_inc;
                    if (run_inc >= attack_reg) begin
                        active_reg <= 1'b1;
                        hang_reg   <= hangover_reg;
                    end
                end else begin
                    run_reg <= '0;
                    if (active_reg) begin
                        hang_reg <= hang_dec;
                        if (hang_dec == '0) active_reg <= 1'b0;
                    end
                end
            end
            if (cmd.noise) begin
                noise_reg <= (noise_adj < nf_min_reg) ? nf_min_reg : noise_adj;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.adapt) begin
            delta_reg <= speech_reg ? (diff >> RISE_SHIFT) : (diff >> TRACK_SHIFT);
            add_reg   <= up;
            sub_reg   <= !up && !speech_reg;
        end
    end

    // output word
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    assign sts.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {frm_total_reg, spc_total_reg, noise_reg, energy,
                            speech_reg, active_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/energy_voice_activity_gate_unit.sv =====
// Energy voice activity gate, top level. Takes one sample word per cycle
// within a frame; a closing word stalls the input while the bit-serial divider
// and the threshold, gate, noise and output steps run.
// The result word is registered and waits for m_tready; accumulation of the
// next frame goes on meanwhile. Synchronous active-low reset clears counters,
// settings to their defaults and the noise floor to 40000.
module energy_voice_activity_gate_unit
    import evag_pkg::*;
#(
    parameter int MAX_FRAME   = 4096,
    parameter int RATIO_SCALE = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [0] voice_active, [1] frame_is_speech, [32:2] frame_energy,
    // [63:33] noise_floor, [95:64] speech_frame_total, [127:96] frame_total
    output logic [OUT_W-1:0]    m_tdata,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    evag_cmd_t cmd;
    evag_sts_t sts;

    evag_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    evag_dpath #(
        .MAX_FRAME   (MAX_FRAME),
        .RATIO_SCALE (RATIO_SCALE)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== rtl/evag_checker.sv =====
// Port-level checks for the energy voice activity gate.
// Bound onto energy_voice_activity_gate_unit; depends on evag_pkg.
module evag_checker
    import evag_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tlast,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OUT_W-1:0]    m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word changed while stalled");

    a_close_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input not held off after frame end");

    a_energy_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[32:2] <= 31'h4000_0000))
        else $error("frame energy above full-scale square");

    a_result_after_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a frame close");

endmodule

bind energy_voice_activity_gate_unit evag_checker u_evag_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/gate_check_pkg.sv =====
`timescale 1ns / 100ps
// Frame predictor and result scoreboard for the energy voice activity gate.
// Depends on evag_pkg for widths, register indexes and reset values.
package gate_check_pkg;
    import evag_pkg::*;

    localparam int FRAME_CAP  = 4096;
    localparam int RATIO_UNIT = 256;

    // first member sits in the top bits, so this matches m_tdata
    typedef struct packed {
        logic [TOTAL_W-1:0]  frame_total;
        logic [TOTAL_W-1:0]  speech_total;
        logic [ENERGY_W-1:0] noise_floor;
        logic [ENERGY_W-1:0] frame_energy;
        logic                frame_is_speech;
        logic                voice_active;
    } gate_result_t;

    class gate_scoreboard;
        logic [RATIO_W-1:0]  ratio_q;
        logic [CFG_W-1:0]    floor_min_q;
        logic [FRAMES_W-1:0] attack_q;
        logic [FRAMES_W-1:0] hang_q;

        logic [42:0]         acc_sq;
        logic [12:0]         acc_n;
        logic [ENERGY_W-1:0] noise_q;
        logic [FRAMES_W-1:0] run_q;
        logic [FRAMES_W-1:0] hang_left_q;
        logic                gate_q;
        logic [TOTAL_W-1:0]  speech_cnt_q;
        logic [TOTAL_W-1:0]  frame_cnt_q;

        gate_result_t frames_due[$];
        int errors;
        int checked;
        int speech_seen;
        int held_seen;

        function new();
            ratio_q      = RATIO_RST;
            floor_min_q  = NF_MIN_RST;
            attack_q     = ATTACK_RST;
            hang_q       = HANGOVER_RST;
            acc_sq       = '0;
            acc_n        = '0;
            noise_q      = NF_MIN_RST;
            run_q        = '0;
            hang_left_q  = '0;
            gate_q       = 1'b0;
            speech_cnt_q = '0;
            frame_cnt_q  = '0;
            errors       = 0;
            checked      = 0;
            speech_seen  = 0;
            held_seen    = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_SPEECH_RATIO:    ratio_q     = val[RATIO_W-1:0];
                REG_NOISE_FLOOR_MIN: floor_min_q = val;
                REG_ATTACK_FRAMES:   attack_q    = val[FRAMES_W-1:0];
                REG_HANGOVER_FRAMES: hang_q      = val[FRAMES_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return frames_due.size();
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] smp, logic lst);
            logic [16:0]         mag;
            logic [ENERGY_W-1:0] energy;
            logic [63:0]         thresh;
            logic [31:0]         level;
            logic                speech;
            int                  shift;
            gate_result_t        r;
            mag = smp[15] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
            acc_sq = acc_sq + 43'(mag) * 43'(mag);
            acc_n = acc_n + 1'b1;
            if (!lst && acc_n < FRAME_CAP)
                return;
            energy = ENERGY_W'(acc_sq / 43'(acc_n));
            acc_sq = '0;
            acc_n  = '0;
            thresh = (64'(noise_q) * 64'(ratio_q)) / 64'(RATIO_UNIT);
            speech = 64'(energy) > thresh;
            frame_cnt_q = frame_cnt_q + 1'b1;
            if (speech) begin
                speech_cnt_q = speech_cnt_q + 1'b1;
                if (run_q != RUN_MAX)
                    run_q = run_q + 1'b1;
                if (run_q >= attack_q) begin
                    gate_q      = 1'b1;
                    hang_left_q = hang_q;
                end
            end else begin
                run_q = '0;
                if (gate_q) begin
                    if (hang_left_q != 0)
                        hang_left_q = hang_left_q - 1'b1;
                    if (hang_left_q == 0)
                        gate_q = 1'b0;
                end
            end
            shift = speech ? RISE_SHIFT : TRACK_SHIFT;
            level = 32'(noise_q);
            if (32'(energy) > level)
                level = level + ((32'(energy) - level) >> shift);
            else if (!speech)
                level = level - ((level - 32'(energy)) >> shift);
            if (level < 32'(floor_min_q))
                level = 32'(floor_min_q);
            noise_q = level[ENERGY_W-1:0];
            r.voice_active    = gate_q;
            r.frame_is_speech = speech;
            r.frame_energy    = energy;
            r.noise_floor     = noise_q;
            r.speech_total    = speech_cnt_q;
            r.frame_total     = frame_cnt_q;
            frames_due.push_back(r);
        endfunction

        function void check_word(gate_result_t got);
            gate_result_t want;
            if (frames_due.size() == 0) begin
                $error("result word with no frame pending");
                errors++;
                return;
            end
            want = frames_due.pop_front();
            checked++;
            if (want.frame_is_speech)
                speech_seen++;
            if (want.voice_active)
                held_seen++;
            if (got.voice_active !== want.voice_active) begin
                $error("voice_active: expected %0d, got %0d", want.voice_active,
                       got.voice_active);
                errors++;
            end
            if (got.frame_is_speech !== want.frame_is_speech) begin
                $error("frame_is_speech: expected %0d, got %0d", want.frame_is_speech,
                       got.frame_is_speech);
                errors++;
            end
            if (got.frame_energy !== want.frame_energy) begin
                $error("frame_energy: expected %0d, got %0d", want.frame_energy,
                       got.frame_energy);
                errors++;
            end
            if (got.noise_floor !== want.noise_floor) begin
                $error("noise_floor: expected %0d, got %0d", want.noise_floor,
                       got.noise_floor);
                errors++;
            end
            if (got.speech_total !== want.speech_total) begin
                $error("speech_frame_total: expected %0d, got %0d", want.speech_total,
                       got.speech_total);
                errors++;
            end
            if (got.frame_total !== want.frame_total) begin
                $error("frame_total: expected %0d, got %0d", want.frame_total,
                       got.frame_total);
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Top-level testbench for energy_voice_activity_gate_unit: drives sample words
// and settings, checks every frame result. Depends on evag_pkg and gate_check_pkg.
module testbench;
    import evag_pkg::*;
    import gate_check_pkg::*;

    localparam int WATCH_LIMIT = 4000;
    localparam int PHASE_WORDS = 225;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata   = '0;
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic                cfg_we    = 1'b0;
    logic [IDX_W-1:0]    cfg_index = REG_SPEECH_RATIO;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    gate_scoreboard board;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int words_sent   = 0;
    int settings_set = 0;
    int quiet_cycles = 0;

    energy_voice_activity_gate_unit #(
        .MAX_FRAME   (FRAME_CAP),
        .RATIO_SCALE (RATIO_UNIT)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_word(gate_result_t'(m_tdata));
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCH_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic lst);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= lst;
        do
            @(posedge aclk);
        while (!s_tready);
        board.note_sample(smp, lst);
        words_sent++;
        @(negedge aclk);
    endtask

    // hold the sender until every frame result is in, then wait out the tail
    task automatic settle(input int tail);
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(negedge aclk);
        repeat (tail) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        board.write_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic apply_setting(input logic [RATIO_W-1:0] ratio, input logic [CFG_W-1:0] floor,
                                 input logic [FRAMES_W-1:0] attack,
                                 input logic [FRAMES_W-1:0] hang);
        write_reg(REG_SPEECH_RATIO, CFG_W'(ratio));
        write_reg(REG_NOISE_FLOOR_MIN, floor);
        write_reg(REG_ATTACK_FRAMES, CFG_W'(attack));
        write_reg(REG_HANGOVER_FRAMES, CFG_W'(hang));
        cfg_we <= 1'b0;
        settings_set++;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 66; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 66; end
            default: begin idle_pct = 7; stall_pct = 7; end
        endcase
    endtask

    // mostly short quiet or loud frames; some noise words with stray frame marks
    task automatic send_random_frame();
        int roll;
        int len;
        int kind;
        int amp;
        int mag;
        logic [SAMPLE_W-1:0] smp;
        logic lst;
        roll = $urandom_range(0, 99);
        len  = (roll < 80) ? $urandom_range(1, 8) :
               (roll < 95) ? $urandom_range(9, 64) : $urandom_range(65, 300);
        kind = $urandom_range(0, 99);
        amp  = (kind < 45) ? $urandom_range(0, 120) : $urandom_range(300, 32768);
        for (int i = 0; i < len; i++) begin
            if (kind >= 90) begin
                smp = SAMPLE_W'($urandom);
                lst = (i == len - 1) || ($urandom_range(0, 3) == 0);
            end else begin
                mag = $urandom_range(amp / 2, amp);
                smp = $urandom_range(0, 1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
                lst = (i == len - 1);
            end
            send_sample(smp, lst);
        end
    endtask

    initial begin
        int start;
        logic paused;
        board = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: threshold boundary, then extremes
        set_idling(0);
        send_sample(16'd400, 1'b0);
        send_sample(16'd0, 1'b1);
        send_sample(16'd0, 1'b1);
        send_sample(16'd283, 1'b1);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b1);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b1);
        settle(60);

        // ratio below unity, zero floor, zero attack and hangover
        apply_setting(16'd128, 31'd0, 16'd0, 16'd0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'd0, 1'b1);
        send_sample(16'd0, 1'b1);
        send_sample(16'd1, 1'b1);
        send_sample(16'hFF00, 1'b1);
        settle(60);

        apply_setting(16'hFFFF, 31'h4000_0000, 16'hFFFF, 16'hFFFF);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'd0, 1'b1);
        send_sample(16'h7FFF, 1'b1);
        settle(60);

        // restore defaults under light idling on both sides
        apply_setting(RATIO_RST, CFG_W'(NF_MIN_RST), ATTACK_RST, HANGOVER_RST);
        set_idling(3);
        send_sample(16'h8000, 1'b0);
        send_sample(16'd7, 1'b1);
        settle(60);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: apply_setting(16'd512, 31'd1000, 16'd2, 16'd25);
                1: apply_setting(16'd256, 31'd0, 16'd1, 16'd0);
                2: apply_setting(16'hFFFF, 31'h4000_0000, 16'hFFFF, 16'hFFFF);
                3: apply_setting(16'd384, 31'd200, 16'd3, 16'd5);
                default: apply_setting(RATIO_W'($urandom_range(256, 1536)),
                                       CFG_W'($urandom_range(0, 5000)),
                                       FRAMES_W'($urandom_range(1, 4)),
                                       FRAMES_W'($urandom_range(0, 10)));
            endcase
            set_idling(ph % 4);
            start  = words_sent;
            paused = 1'b0;
            while (words_sent - start < PHASE_WORDS) begin
                send_random_frame();
                if (!paused && words_sent - start >= PHASE_WORDS / 2) begin
                    settle(0);
                    paused = 1'b1;
                end
            end
            settle(60);
        end

        $display("%0d sample words sent over %0d register settings and four idling patterns",
                 words_sent, settings_set);
        $display("%0d frames checked: %0d speech, %0d with the gate held",
                 board.checked, board.speech_seen, board.held_seen);
        if (board.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
